FILE: rtl/core/slru_pkg.sv
// Shared constants, types and codes of the LRU tag directory.
package slru_pkg;

    // Directory geometry
    localparam int MAX_SETS = 256;
    localparam int MAX_WAYS = 8;
    localparam int SET_W    = $clog2(MAX_SETS);
    localparam int WAY_W    = $clog2(MAX_WAYS);
    localparam int AGE_W    = $clog2(MAX_WAYS);
    localparam int TAG_W    = 32;
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 32;

    // Register field widths
    localparam int OFF_W      = 5;
    localparam int IDXB_W     = 4;
    localparam int WAYS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int TSH_W      = 6;

    // Packed result width, rounded up to whole bytes
    localparam int RES_W = 1 + SET_W + 1 + TAG_W + CNT_W + CNT_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOK
    } t_state;

    // Effective configuration (index width and ways already clamped)
    typedef struct packed {
        logic [OFF_W-1:0]  offset_bits;
        logic [IDXB_W-1:0] index_bits;
        logic [WAYS_W-1:0] ways;
    } t_cfg;

    // One set of the directory
    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    } t_row;

    // Lookup outcome and the updated set
    typedef struct packed {
        logic             hit;
        logic             victim_valid;
        logic [TAG_W-1:0] victim_tag;
        t_row             row;
    } t_upd;

endpackage

FILE: rtl/core/slru_cfg.sv
// Configuration registers with clamping of index width and ways.
module slru_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [slru_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [slru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output slru_pkg::t_cfg                 o_cfg
);
    import slru_pkg::*;

    logic [OFF_W-1:0]  r_offset, n_offset;
    logic [IDXB_W-1:0] r_index,  n_index;
    logic [WAYS_W-1:0] r_ways,   n_ways;

    assign o_cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        n_offset = r_offset;
        n_index  = r_index;
        n_ways   = r_ways;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET: n_offset = i_cfg_data[OFF_W-1:0];
                CFG_INDEX:  n_index  = i_cfg_data[IDXB_W-1:0];
                CFG_WAYS:   n_ways   = i_cfg_data[WAYS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFF_W'(6);
            r_index  <= IDXB_W'(SET_W);
            r_ways   <= WAYS_W'(MAX_WAYS);
        end else begin
            r_offset <= n_offset;
            r_index  <= n_index;
            r_ways   <= n_ways;
        end
    end

    // Clamp to the sets and ways that exist
    always_comb begin
        o_cfg.offset_bits = r_offset;
        o_cfg.index_bits  = (r_index > IDXB_W'(SET_W)) ? IDXB_W'(SET_W) : r_index;
        if (r_ways == '0)
            o_cfg.ways = WAYS_W'(1);
        else if (r_ways > WAYS_W'(MAX_WAYS))
            o_cfg.ways = WAYS_W'(MAX_WAYS);
        else
            o_cfg.ways = r_ways;
    end

endmodule

FILE: rtl/core/slru_dir.sv
// Directory storage: tag and state memories, one row per set, with row valid flags.
module slru_dir (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [slru_pkg::SET_W-1:0] i_rd_set,
    output slru_pkg::t_row             o_rd_row,
    input  logic                       i_wr_en,
    input  logic [slru_pkg::SET_W-1:0] i_wr_set,
    input  slru_pkg::t_row             i_wr_row
);
    import slru_pkg::*;

    localparam int TROW_W = MAX_WAYS * TAG_W;
    localparam int MROW_W = MAX_WAYS * (1 + AGE_W);

    logic [TROW_W-1:0] mem_tag  [MAX_SETS];
    logic [MROW_W-1:0] mem_meta [MAX_SETS];
    logic [MAX_SETS-1:0] r_row_vld;

    logic [TROW_W-1:0] r_rd_tag;
    logic [MROW_W-1:0] r_rd_meta;
    logic              r_rd_vld;

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_tag[i_wr_set]  <= i_wr_row.tag;
            mem_meta[i_wr_set] <= {i_wr_row.valid, i_wr_row.age};
        end
        if (i_rd_en) begin
            r_rd_tag  <= mem_tag[i_rd_set];
            r_rd_meta <= mem_meta[i_rd_set];
        end
    end

    // A set never written reads as all lines invalid, age zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en)
                r_row_vld[i_wr_set] <= 1'b1;
            if (i_rd_en)
                r_rd_vld <= r_row_vld[i_rd_set];
        end
    end

    always_comb begin
        o_rd_row.tag = r_rd_tag;
        {o_rd_row.valid, o_rd_row.age} = r_rd_vld ? r_rd_meta : '0;
    end

endmodule

FILE: rtl/core/slru_lru.sv
// Tag compare, way selection and true LRU age update for one set.
module slru_lru (
    input  slru_pkg::t_row                 i_row,
    input  logic [slru_pkg::TAG_W-1:0]     i_tag,
    input  logic [slru_pkg::WAYS_W-1:0]    i_ways,
    output slru_pkg::t_upd                 o_upd
);
    import slru_pkg::*;

    logic [MAX_WAYS-1:0] in_use, match, free;
    logic [WAY_W-1:0]    hit_way, free_way, vic_way, target;
    logic [AGE_W-1:0]    best, tgt_age;
    logic                hit, any_free, full;

    // Per-way flags
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = WAYS_W'(w) < i_ways;
            match[w]  = in_use[w] && i_row.valid[w] && (i_row.tag[w] == i_tag);
            free[w]   = in_use[w] && !i_row.valid[w];
        end
    end

    // Lowest matching way, lowest free way, oldest way (lowest on a tie)
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w])
                hit_way = WAY_W'(w);
            if (free[w])
                free_way = WAY_W'(w);
        end
        best    = '0;
        vic_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && (i_row.age[w] > best)) begin
                best    = i_row.age[w];
                vic_way = WAY_W'(w);
            end
        end
    end

    assign hit      = |match;
    assign any_free = |free;
    assign full     = !hit && !any_free;
    assign target   = hit ? hit_way : (any_free ? free_way : vic_way);
    assign tgt_age  = i_row.age[target];

    // New set contents
    always_comb begin
        o_upd.hit          = hit;
        o_upd.victim_valid = full;
        o_upd.victim_tag   = full ? i_row.tag[vic_way] : '0;
        o_upd.row          = i_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == target) begin
                o_upd.row.age[w]   = '0;
                o_upd.row.valid[w] = 1'b1;
                o_upd.row.tag[w]   = i_tag;
            end else if (in_use[w] && i_row.valid[w] && (i_row.age[w] != AGE_MAX)
                         && (!hit || (i_row.age[w] < tgt_age))) begin
                o_upd.row.age[w] = i_row.age[w] + AGE_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/set_assoc_lru_tag_lookup.sv
// Top level of the set-associative tag directory with true LRU replacement.
//
// Usage:
//   Slave stream (i_s_*): one item is one 32-bit byte address.
//   Master stream (o_m_*): one result item per address: hit flag, set index,
//   evicted line flag and tag, and the saturating hit and miss totals
//   counting this access.
//   Config channel (i_cfg_*): index 0 offset bits, 1 index bits, 2 ways in use;
//   always ready; the user writes it only while no item is in flight, and the
//   block itself does not enforce this.
// Flow: one item is in flight at a time. The set row is read from the directory
//   memory when the address is accepted and written back when the lookup completes,
//   so the next address is taken only after the write, which removes any same-set hazard.
// Reset: registers return to 6 / 8 / 8, totals to zero, and a flag per set
//   marks all lines invalid at once; no clearing sweep is needed.
// Stall: a result waits in the output register while o_m_tvalid is high and
//   i_m_tready is low; the next lookup holds in S_LOOK until the
//   register is free, and its row write waits with it.
module set_assoc_lru_tag_lookup (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // address
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [slru_pkg::ADDR_W-1:0]     i_s_tdata,
    // hit, set_index, victim_valid, victim_tag, hit_total, miss_total, zero pad
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [slru_pkg::OUT_W-1:0]      o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [slru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slru_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slru_pkg::*;

    t_cfg   cfg;
    t_row   rd_row;
    t_upd   upd;
    t_state r_state, n_state;

    logic                 accept, complete;
    logic [ADDR_W-1:0]    shifted;
    logic [SET_W-1:0]     set_mask, in_set;
    logic [TSH_W-1:0]     tshift;
    logic [TAG_W-1:0]     in_tag;
    logic [SET_W-1:0]     r_set;
    logic [TAG_W-1:0]     r_tag;
    logic [CNT_W-1:0]     r_hit_cnt, n_hit_cnt, r_miss_cnt, n_miss_cnt;
    logic                 r_m_valid;
    logic [RES_W-1:0]     r_m_data;

    slru_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    slru_dir u_dir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_set (in_set),
        .o_rd_row (rd_row),
        .i_wr_en  (complete),
        .i_wr_set (r_set),
        .i_wr_row (upd.row)
    );

    slru_lru u_lru (
        .i_row  (rd_row),
        .i_tag  (r_tag),
        .i_ways (cfg.ways),
        .o_upd  (upd)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign complete   = (r_state == S_LOOK) && (!r_m_valid || i_m_tready);

    // Address split into set and tag
    always_comb begin
        shifted  = i_s_tdata >> cfg.offset_bits;
        set_mask = ~({SET_W{1'b1}} << cfg.index_bits);
        in_set   = shifted[SET_W-1:0] & set_mask;
        tshift   = TSH_W'(cfg.offset_bits) + TSH_W'(cfg.index_bits);
        in_tag   = (tshift >= TSH_W'(ADDR_W)) ? '0 : (i_s_tdata >> tshift);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= in_set;
            r_tag <= in_tag;
        end
    end

    // Lookup sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_LOOK;
            S_LOOK:  if (complete) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Saturating totals
    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (upd.hit) begin
            if (r_hit_cnt != CNT_MAX)
                n_hit_cnt = r_hit_cnt + CNT_W'(1);
        end else begin
            if (r_miss_cnt != CNT_MAX)
                n_miss_cnt = r_miss_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else if (complete) begin
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_m_valid <= 1'b0;
        else if (complete)
            r_m_valid <= 1'b1;
        else if (i_m_tready)
            r_m_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (complete)
            r_m_data <= {n_miss_cnt, n_hit_cnt, upd.victim_tag, upd.victim_valid,
                         r_set, upd.hit};
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_W'(r_m_data);

    // Checks
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK))
        else $error("accepted item did not start a lookup");

    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_data[0] && r_m_data[SET_W+1]))
        else $error("hit result reports an evicted line");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        complete |=> ($stable(r_hit_cnt) || $stable(r_miss_cnt)))
        else $error("both totals changed for one item");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !complete |=> ($stable(r_hit_cnt) && $stable(r_miss_cnt)))
        else $error("totals changed without a lookup");

    a_no_read_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && complete))
        else $error("directory read and write in the same cycle");

endmodule
